// File: design/gtw_pkg.sv
package gtw_pkg;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int IDX_W = 30;
  localparam int WEIGHT_W = 17;
  localparam logic [2:0] CORNER_LAST = 3'd7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_GRID_DIMS
  } gtw_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } gtw_point_t;

  typedef struct packed {
    logic [2:0]          corner;
    logic [IDX_W-1:0]    cell_index;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } gtw_result_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } gtw_q_status_t;

endpackage

// File: design/gtw_axis.sv
module gtw_axis #(
  parameter int DIM_BITS = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [31:0]          pt,
  input  logic [31:0]          org,
  input  logic [31:0]          scl,
  input  logic [DIM_BITS-1:0]  n,
  output logic [DIM_BITS-1:0]  cell_pos,
  output logic [FRAC_BITS:0]   frac
);
  localparam int SHIFT_W = 32 + FRAC_BITS;
  localparam int C_W = DIM_BITS + FRAC_BITS;

  logic [32:0]          diff;
  logic [31:0]          du;
  logic                 pos;
  logic [47:0]          hi_next;
  logic [47:0]          lo_next;
  logic [47:0]          hi;
  logic [47:0]          lo;
  logic                 pos2;
  logic [63:0]          prod;
  logic [SHIFT_W-1:0]   shifted;
  logic [C_W-1:0]       cmax;
  logic [C_W-1:0]       c_next;
  logic [C_W-1:0]       c;
  logic [DIM_BITS-1:0]  ci;
  logic [DIM_BITS-1:0]  nm2;

  // difference of point and origin
  always_comb begin
    diff = {pt[31], pt} - {org[31], org};
  end

  always_ff @(posedge clk) begin
    du  <= diff[31:0];
    pos <= !diff[32] && (diff[31:0] != 32'd0);
  end

  // split product by scale halves
  always_comb begin
    hi_next = du * scl[31:16];
    lo_next = du * scl[15:0];
  end

  always_ff @(posedge clk) begin
    hi   <= hi_next;
    lo   <= lo_next;
    pos2 <= pos;
  end

  // coordinate, clamped to zero at or below the origin and saturated at the far edge
  always_comb begin
    prod    = {hi[47:0], 16'h0000} + {16'h0000, lo};
    shifted = prod[63:32-FRAC_BITS];
    cmax    = {n - DIM_BITS'(1), {FRAC_BITS{1'b0}}};
    if (!pos2) begin
      c_next = '0;
    end else if (hi[47] || (shifted > SHIFT_W'(cmax))) begin
      c_next = cmax;
    end else begin
      c_next = shifted[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    c <= c_next;
  end

  // cell and fraction
  always_comb begin
    ci  = c[C_W-1:FRAC_BITS];
    nm2 = n - DIM_BITS'(2);
  end

  always_ff @(posedge clk) begin
    if (ci > nm2) begin
      cell_pos <= nm2;
      frac     <= {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      cell_pos <= ci;
      frac     <= {1'b0, c[FRAC_BITS-1:0]};
    end
  end

endmodule

// File: design/gtw_front.sv
module gtw_front #(
  parameter int DIM_BITS = 10,
  parameter int FRAC_BITS = 16,
  localparam int ENTRY_W = gtw_pkg::IDX_W + 3 * (FRAC_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        point_valid,
  output logic                        point_stall,
  input  gtw_pkg::gtw_point_t         point,
  input  logic [31:0]                 origin_x,
  input  logic [31:0]                 origin_y,
  input  logic [31:0]                 origin_z,
  input  logic [31:0]                 scale_x,
  input  logic [31:0]                 scale_y,
  input  logic [31:0]                 scale_z,
  input  logic [DIM_BITS-1:0]         nx,
  input  logic [DIM_BITS-1:0]         ny,
  input  logic [DIM_BITS-1:0]         nz,
  input  logic [gtw_pkg::IDX_W-1:0]   nxny,
  input  gtw_pkg::gtw_q_status_t      q_status,
  output logic                        push,
  output logic [ENTRY_W-1:0]          push_data
);
  import gtw_pkg::*;

  localparam int STAGES = 5;
  localparam int LOAD_W = QCNT_W + 1;
  localparam int FW = FRAC_BITS + 1;

  logic                accept;
  logic [STAGES-1:0]   vld;
  logic [LOAD_W-1:0]   load;
  logic [DIM_BITS-1:0] cell_x;
  logic [DIM_BITS-1:0] cell_y;
  logic [DIM_BITS-1:0] cell_z;
  logic [FW-1:0]       frac_x;
  logic [FW-1:0]       frac_y;
  logic [FW-1:0]       frac_z;
  logic [IDX_W-1:0]    base;
  logic [FW-1:0]       fx;
  logic [FW-1:0]       fy;
  logic [FW-1:0]       fz;

  // queue slots already spoken for, including items still in flight
  always_comb begin
    load = LOAD_W'(q_status.count);
    for (int i = 0; i < STAGES; i++) begin
      load = load + LOAD_W'(vld[i]);
    end
  end

  assign point_stall = rst || (load >= LOAD_W'(QDEPTH));
  assign accept = point_valid && !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], accept};
    end
  end

  gtw_axis #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk      (clk),
    .pt       (point.point_x),
    .org      (origin_x),
    .scl      (scale_x),
    .n        (nx),
    .cell_pos (cell_x),
    .frac     (frac_x)
  );

  gtw_axis #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk      (clk),
    .pt       (point.point_y),
    .org      (origin_y),
    .scl      (scale_y),
    .n        (ny),
    .cell_pos (cell_y),
    .frac     (frac_y)
  );

  gtw_axis #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk      (clk),
    .pt       (point.point_z),
    .org      (origin_z),
    .scl      (scale_z),
    .n        (nz),
    .cell_pos (cell_z),
    .frac     (frac_z)
  );

  // linear index of the base corner
  always_ff @(posedge clk) begin
    base <= IDX_W'(cell_x) + IDX_W'(cell_y) * IDX_W'(nx) + IDX_W'(cell_z) * nxny;
    fx   <= frac_x;
    fy   <= frac_y;
    fz   <= frac_z;
  end

  assign push = vld[STAGES-1];
  assign push_data = {base, fx, fy, fz};

endmodule

// File: design/gtw_fifo.sv
module gtw_fifo #(
  parameter int WIDTH = 81
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       head_data,
  output gtw_pkg::gtw_q_status_t status
);
  import gtw_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  logic [WIDTH-1:0]  mem [QDEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  assign head_data = mem[rptr];
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

// File: design/gtw_back.sv
module gtw_back #(
  parameter int DIM_BITS = 10,
  parameter int FRAC_BITS = 16,
  localparam int ENTRY_W = gtw_pkg::IDX_W + 3 * (FRAC_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gtw_pkg::gtw_q_status_t      q_status,
  input  logic [ENTRY_W-1:0]          head_data,
  input  logic [DIM_BITS-1:0]         nx,
  input  logic [gtw_pkg::IDX_W-1:0]   nxny,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output gtw_pkg::gtw_result_t        result
);
  import gtw_pkg::*;

  localparam int FW = FRAC_BITS + 1;
  localparam int PROD_W = 2 * FW;
  localparam int SH = 2 * FRAC_BITS - 16;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND = PROD_W'((1 << SH) >> 1);

  logic               en;
  logic               issue;
  logic [2:0]         corner;
  logic [IDX_W-1:0]   base;
  logic [FW-1:0]      fx;
  logic [FW-1:0]      fy;
  logic [FW-1:0]      fz;
  logic               ox;
  logic               oy;
  logic               oz;
  logic [FW-1:0]      ax;
  logic [FW-1:0]      ay;
  logic [FW-1:0]      az;
  logic [IDX_W-1:0]   idx;
  logic               v1;
  logic [PROD_W-1:0]  prod1;
  logic [FW-1:0]      az1;
  logic [IDX_W-1:0]   idx1;
  logic [2:0]         corner1;
  logic [PROD_W-1:0]  p_full;
  logic [FW-1:0]      p;
  logic               v2;
  logic [PROD_W-1:0]  q2;
  logic [IDX_W-1:0]   idx2;
  logic [2:0]         corner2;
  logic [PROD_W-1:0]  w_full;

  assign en = !result_valid || !result_stall;
  assign issue = en && !q_status.empty;
  assign pop = issue && (corner == CORNER_LAST);

  // corner offsets, x offset is corner[0] ^ corner[1] so each xy face is walked in a loop
  always_comb begin
    base = head_data[ENTRY_W-1 -: IDX_W];
    fx   = head_data[3*FW-1 -: FW];
    fy   = head_data[2*FW-1 -: FW];
    fz   = head_data[FW-1:0];
    ox   = corner[0] ^ corner[1];
    oy   = corner[1];
    oz   = corner[2];
    ax   = ox ? fx : ONE - fx;
    ay   = oy ? fy : ONE - fy;
    az   = oz ? fz : ONE - fz;
    idx  = base + IDX_W'(ox) + (oy ? IDX_W'(nx) : '0) + (oz ? nxny : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner       <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= !q_status.empty;
      v2           <= v1;
      result_valid <= v2;
      if (!q_status.empty) begin
        corner <= corner + 3'd1;
      end
    end
  end

  always_comb begin
    p_full = (prod1 + HALF) >> FRAC_BITS;
    p      = p_full[FW-1:0];
    w_full = (q2 + RND) >> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1             <= ax * ay;
      az1               <= az;
      idx1              <= idx;
      corner1           <= corner;
      q2                <= p * az1;
      idx2              <= idx1;
      corner2           <= corner1;
      result.corner     <= corner2;
      result.cell_index <= idx2;
      result.weight     <= w_full[WEIGHT_W-1:0];
      result.last       <= (corner2 == CORNER_LAST);
    end
  end

endmodule

// File: design/grid_trilinear_weights.sv
// channel   direction  payload        handshake
// config    in         apb registers  psel, penable, pwrite, pready
// point     in         gtw_point_t    point_valid, point_stall
// result    out        gtw_result_t   result_valid, result_stall
//
// one corner transfer per cycle unless stalled or queue empty; points queue while corners run
// a point passes the front pipeline, the queue and back registers v1, v2, result to its first corner
// reset clears the queue, pipeline valids and corner count; registers take their reset values
// a stalled result freezes the corner pipeline; the front stalls at QDEPTH queued or in-flight points
module grid_trilinear_weights #(
  parameter int DIM_BITS = 10,
  parameter int FRAC_BITS = 16,
  localparam int DATA_W = (3 * DIM_BITS > 32) ? 64 : 32,
  localparam int ADDR_W = (DATA_W == 64) ? 6 : 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  gtw_pkg::gtw_point_t   point,
  output logic                  result_valid,
  input  logic                  result_stall,
  output gtw_pkg::gtw_result_t  result
);
  import gtw_pkg::*;

  localparam int DIMS_W = 3 * DIM_BITS;
  localparam int ENTRY_W = IDX_W + 3 * (FRAC_BITS + 1);
  localparam logic [DIMS_W-1:0] DIMS_RESET = {DIM_BITS'(2), DIM_BITS'(52), DIM_BITS'(2)};

  logic                wr_en;
  gtw_reg_t            reg_idx;
  logic [31:0]         origin_x;
  logic [31:0]         origin_y;
  logic [31:0]         origin_z;
  logic [31:0]         scale_x;
  logic [31:0]         scale_y;
  logic [31:0]         scale_z;
  logic [DIMS_W-1:0]   grid_dims;
  logic [DIM_BITS-1:0] nx_raw;
  logic [DIM_BITS-1:0] ny_raw;
  logic [DIM_BITS-1:0] nz_raw;
  logic [DIM_BITS-1:0] nx;
  logic [DIM_BITS-1:0] ny;
  logic [DIM_BITS-1:0] nz;
  logic [IDX_W-1:0]    nxny;
  gtw_q_status_t       q_status;
  logic                push;
  logic [ENTRY_W-1:0]  push_data;
  logic                pop;
  logic [ENTRY_W-1:0]  head_data;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign reg_idx = gtw_reg_t'(paddr[ADDR_W-1:ADDR_W-3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      scale_x   <= 32'h0001_0000;
      scale_y   <= 32'h0001_0000;
      scale_z   <= 32'h0001_0000;
      grid_dims <= DIMS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X:  origin_x  <= pwdata[31:0];
        REG_ORIGIN_Y:  origin_y  <= pwdata[31:0];
        REG_ORIGIN_Z:  origin_z  <= pwdata[31:0];
        REG_SCALE_X:   scale_x   <= pwdata[31:0];
        REG_SCALE_Y:   scale_y   <= pwdata[31:0];
        REG_SCALE_Z:   scale_z   <= pwdata[31:0];
        REG_GRID_DIMS: grid_dims <= pwdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:  prdata = DATA_W'(origin_x);
      REG_ORIGIN_Y:  prdata = DATA_W'(origin_y);
      REG_ORIGIN_Z:  prdata = DATA_W'(origin_z);
      REG_SCALE_X:   prdata = DATA_W'(scale_x);
      REG_SCALE_Y:   prdata = DATA_W'(scale_y);
      REG_SCALE_Z:   prdata = DATA_W'(scale_z);
      REG_GRID_DIMS: prdata = DATA_W'(grid_dims);
      default:       prdata = '0;
    endcase
  end

  // point counts below two count as two
  always_comb begin
    nx_raw = grid_dims[DIM_BITS-1:0];
    ny_raw = grid_dims[2*DIM_BITS-1:DIM_BITS];
    nz_raw = grid_dims[3*DIM_BITS-1:2*DIM_BITS];
    nx = (nx_raw < DIM_BITS'(2)) ? DIM_BITS'(2) : nx_raw;
    ny = (ny_raw < DIM_BITS'(2)) ? DIM_BITS'(2) : ny_raw;
    nz = (nz_raw < DIM_BITS'(2)) ? DIM_BITS'(2) : nz_raw;
  end

  always_ff @(posedge clk) begin
    nxny <= IDX_W'(nx) * IDX_W'(ny);
  end

  gtw_front #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .scale_x     (scale_x),
    .scale_y     (scale_y),
    .scale_z     (scale_z),
    .nx          (nx),
    .ny          (ny),
    .nz          (nz),
    .nxny        (nxny),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  gtw_fifo #(.WIDTH(ENTRY_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  gtw_back #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_data    (head_data),
    .nx           (nx),
    .nxny         (nxny),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: design/gtw_checker.sv
module gtw_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_stall,
  input gtw_pkg::gtw_result_t result
);
  import gtw_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.corner == CORNER_LAST)))
    else $error("last flag does not match corner");

  a_corner_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=>
      result_valid && (result.corner == $past(result.corner) + 3'd1))
    else $error("corners of a point not contiguous");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.weight <= WEIGHT_ONE))
    else $error("weight above one");

endmodule

bind grid_trilinear_weights gtw_checker u_gtw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
